[design/coupled_oscillator_euler_step_assert.svh]
// assertion macros shared by the oscillator step block
`ifndef COUPLED_OSCILLATOR_EULER_STEP_ASSERT_SVH
`define COUPLED_OSCILLATOR_EULER_STEP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define COE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("coe assertion failed");

// next-cycle implication, checked out of reset
`define COE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("coe assertion failed");

`endif

[design/coe_pkg.sv]
// types and constants of the coupled oscillator step block
`default_nettype none

package coe_pkg;

    localparam int WORD_W     = 32;
    localparam int STIFF_W    = 31;
    localparam int STEP_W     = 25;
    localparam int MULT_W     = 31;
    localparam int NSUM_W     = 35;
    localparam int MAG_W      = 34;
    localparam int HALF_W     = 17;
    localparam int PROD_W     = HALF_W + MULT_W;
    localparam int ACC_W      = MAG_W + MULT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word WORD_MAX = 32'h7fff_ffff;
    localparam t_word WORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic  action;
        t_word init_pos_a;
        t_word init_vel_a;
        t_word init_pos_b;
        t_word init_vel_b;
        t_word init_pos_c;
        t_word init_vel_c;
    } t_in_item;

    typedef struct packed {
        t_word out_pos_a;
        t_word out_pos_b;
        t_word out_pos_c;
        logic  saturated;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_POS,
        PH_ACC,
        PH_VEL
    } t_phase;

    typedef struct packed {
        logic   load;
        logic   clr_flag;
        logic   setup;
        logic   mul_lo;
        logic   mul_hi;
        logic   round;
        logic   finish;
        logic   write_out;
        t_phase phase;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_sts;

endpackage

`default_nettype wire

[design/coe_in_if.sv]
// input item channel
`default_nettype none

interface coe_in_if;
    import coe_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/coe_out_if.sv]
// result item channel
`default_nettype none

interface coe_out_if;
    import coe_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/coe_cfg_if.sv]
// configuration write channel
`default_nettype none

interface coe_cfg_if;
    import coe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/coe_dp.sv]
// datapath: state, config registers, three multiply lanes and result register
`default_nettype none

module coe_dp #(
    parameter int FRAC_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  coe_pkg::t_dp_cmd               i_cmd,
    output coe_pkg::t_dp_sts               o_sts,
    input  coe_pkg::t_in_item              i_in_data,
    input  logic                           i_cfg_fire,
    input  logic [coe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [coe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_out_ready,
    output coe_pkg::t_out_item             o_out_data
);
    import coe_pkg::*;

    localparam int Q_W   = ACC_W - FRAC_BITS;
    localparam int TOT_W = Q_W + 2;
    localparam logic [ACC_W-1:0]   RND_HALF    = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [STIFF_W-1:0] STIFF_RESET = STIFF_W'(64'd1 << FRAC_BITS);
    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'((64'd1 << FRAC_BITS) / 100);

    logic [STIFF_W-1:0] r_stiffness;
    logic [STEP_W-1:0]  r_time_step;
    t_word              r_pos [3];
    t_word              r_vel [3];
    t_word              r_acc [3];
    logic               r_neg [3];
    logic [MAG_W-1:0]   r_mag [3];
    logic [PROD_W-1:0]  r_plo [3];
    logic [PROD_W-1:0]  r_phi [3];
    logic [Q_W-1:0]     r_q   [3];
    logic [MULT_W-1:0]  r_mult;
    logic               r_flag;
    logic               r_out_valid;
    t_out_item          r_out_data;

    t_word                    pos_ext [5];
    logic signed [NSUM_W-1:0] nsum    [3];
    logic signed [NSUM_W-1:0] sel     [3];
    logic [MAG_W-1:0]         mag     [3];
    logic [ACC_W-1:0]         rsum    [3];
    logic signed [TOT_W-1:0]  addend  [3];
    logic signed [TOT_W-1:0]  qx      [3];
    logic signed [TOT_W-1:0]  total   [3];
    logic                     ovf     [3];
    t_word                    satv    [3];
    logic                     any_ovf;

    always_comb begin
        pos_ext[0] = '0;
        pos_ext[4] = '0;
        for (int l = 0; l < 3; l++) begin
            pos_ext[l+1] = r_pos[l];
        end
        any_ovf = 1'b0;
        for (int l = 0; l < 3; l++) begin
            // left - 2*self + right, walls read as zero, kept exact
            nsum[l] = {{(NSUM_W-WORD_W){pos_ext[l][WORD_W-1]}}, pos_ext[l]}
                    - ({{(NSUM_W-WORD_W){pos_ext[l+1][WORD_W-1]}}, pos_ext[l+1]} <<< 1)
                    + {{(NSUM_W-WORD_W){pos_ext[l+2][WORD_W-1]}}, pos_ext[l+2]};
            case (i_cmd.phase)
                PH_ACC:  sel[l] = nsum[l];
                PH_VEL:  sel[l] = {{(NSUM_W-WORD_W){r_acc[l][WORD_W-1]}}, r_acc[l]};
                default: sel[l] = {{(NSUM_W-WORD_W){r_vel[l][WORD_W-1]}}, r_vel[l]};
            endcase
            mag[l] = sel[l][NSUM_W-1] ? MAG_W'(-sel[l]) : MAG_W'(sel[l]);

            // magnitude product scaled down, ties away from zero
            rsum[l] = ACC_W'({r_phi[l], {HALF_W{1'b0}}}) + ACC_W'(r_plo[l]) + RND_HALF;

            case (i_cmd.phase)
                PH_POS:  addend[l] = {{(TOT_W-WORD_W){r_pos[l][WORD_W-1]}}, r_pos[l]};
                PH_VEL:  addend[l] = {{(TOT_W-WORD_W){r_vel[l][WORD_W-1]}}, r_vel[l]};
                default: addend[l] = '0;
            endcase
            qx[l]    = {2'b00, r_q[l]};
            total[l] = r_neg[l] ? addend[l] - qx[l] : addend[l] + qx[l];
            ovf[l]   = !((&total[l][TOT_W-1:WORD_W-1]) || !(|total[l][TOT_W-1:WORD_W-1]));
            satv[l]  = ovf[l] ? (total[l][TOT_W-1] ? WORD_MIN : WORD_MAX)
                              : total[l][WORD_W-1:0];
            any_ovf  = any_ovf | ovf[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiffness <= STIFF_RESET;
            r_time_step <= STEP_RESET;
            for (int l = 0; l < 3; l++) begin
                r_pos[l] <= '0;
                r_vel[l] <= '0;
            end
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_fire) begin
                unique case (i_cfg_index)
                    CFG_STIFFNESS: r_stiffness <= i_cfg_data[STIFF_W-1:0];
                    CFG_TIME_STEP: r_time_step <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_pos[0] <= i_in_data.init_pos_a;
                r_vel[0] <= i_in_data.init_vel_a;
                r_pos[1] <= i_in_data.init_pos_b;
                r_vel[1] <= i_in_data.init_vel_b;
                r_pos[2] <= i_in_data.init_pos_c;
                r_vel[2] <= i_in_data.init_vel_c;
            end
            if (i_cmd.finish) begin
                for (int l = 0; l < 3; l++) begin
                    if (i_cmd.phase == PH_POS) begin
                        r_pos[l] <= satv[l];
                    end else if (i_cmd.phase == PH_VEL) begin
                        r_vel[l] <= satv[l];
                    end
                end
            end
            if (i_cmd.clr_flag) begin
                r_flag <= 1'b0;
            end else if (i_cmd.finish && any_ovf) begin
                r_flag <= 1'b1;
            end
            if (i_cmd.write_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_mult <= (i_cmd.phase == PH_ACC) ? r_stiffness : MULT_W'(r_time_step);
            for (int l = 0; l < 3; l++) begin
                r_mag[l] <= mag[l];
                r_neg[l] <= sel[l][NSUM_W-1];
            end
        end
        for (int l = 0; l < 3; l++) begin
            if (i_cmd.mul_lo) begin
                r_plo[l] <= r_mag[l][HALF_W-1:0] * r_mult;
            end
            if (i_cmd.mul_hi) begin
                r_phi[l] <= r_mag[l][MAG_W-1:HALF_W] * r_mult;
            end
            if (i_cmd.round) begin
                r_q[l] <= rsum[l][ACC_W-1:FRAC_BITS];
            end
            if (i_cmd.finish && i_cmd.phase == PH_ACC) begin
                r_acc[l] <= satv[l];
            end
        end
        if (i_cmd.write_out) begin
            r_out_data.out_pos_a <= r_pos[0];
            r_out_data.out_pos_b <= r_pos[1];
            r_out_data.out_pos_c <= r_pos[2];
            r_out_data.saturated <= r_flag;
        end
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

`default_nettype wire

[design/coe_ctrl.sv]
// controller: sequences load and step items through the datapath
`default_nettype none

`include "coupled_oscillator_euler_step_assert.svh"

module coe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_action,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    input  coe_pkg::t_dp_sts i_sts,
    output coe_pkg::t_dp_cmd o_cmd
);
    import coe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P_LO, S_P_HI, S_P_RND, S_P_FIN,
        S_A_SET, S_A_LO, S_A_HI, S_A_RND, S_A_FIN,
        S_V_SET, S_V_LO, S_V_HI, S_V_RND, S_V_FIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.phase = PH_POS;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.clr_flag = 1'b1;
                    if (i_in_action == ACT_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DONE;
                    end else begin
                        // velocities feed the position update first
                        o_cmd.setup = 1'b1;
                        n_state     = S_P_LO;
                    end
                end
            end
            S_P_LO:  begin o_cmd.mul_lo = 1'b1; n_state = S_P_HI; end
            S_P_HI:  begin o_cmd.mul_hi = 1'b1; n_state = S_P_RND; end
            S_P_RND: begin o_cmd.round  = 1'b1; n_state = S_P_FIN; end
            S_P_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_A_SET;
            end
            S_A_SET: begin
                o_cmd.setup = 1'b1;
                o_cmd.phase = PH_ACC;
                n_state     = S_A_LO;
            end
            S_A_LO:  begin o_cmd.mul_lo = 1'b1; n_state = S_A_HI; end
            S_A_HI:  begin o_cmd.mul_hi = 1'b1; n_state = S_A_RND; end
            S_A_RND: begin o_cmd.round  = 1'b1; n_state = S_A_FIN; end
            S_A_FIN: begin
                o_cmd.finish = 1'b1;
                o_cmd.phase  = PH_ACC;
                n_state      = S_V_SET;
            end
            S_V_SET: begin
                o_cmd.setup = 1'b1;
                o_cmd.phase = PH_VEL;
                n_state     = S_V_LO;
            end
            S_V_LO:  begin o_cmd.mul_lo = 1'b1; n_state = S_V_HI; end
            S_V_HI:  begin o_cmd.mul_hi = 1'b1; n_state = S_V_RND; end
            S_V_RND: begin o_cmd.round  = 1'b1; n_state = S_V_FIN; end
            S_V_FIN: begin
                o_cmd.finish = 1'b1;
                o_cmd.phase  = PH_VEL;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // result register frees up when its beat is taken
                if (!i_sts.out_valid || i_out_ready) begin
                    o_cmd.write_out = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `COE_ASSERT_NEXT(a_accept_leaves_idle, in_fire, r_state != S_IDLE && !o_in_ready)
    `COE_ASSERT_NEXT(a_write_holds_result, o_cmd.write_out, i_sts.out_valid)
    `COE_ASSERT_IMPL(a_finish_after_round, o_cmd.finish, $past(o_cmd.round))

endmodule

`default_nettype wire

[design/coupled_oscillator_euler_step.sv]
// Three equal masses in a spring chain between fixed walls, advanced by one
// semi-implicit Euler step per step item (action 1) or loaded with six initial
// values (action 0); all values are signed fixed point with FRAC_BITS fraction
// bits and saturate to 32 bits. A step item runs through the position,
// acceleration and velocity phases and then a done state, a load item goes
// straight to the done state; the result beat is registered from there, and
// the block stays there while an earlier beat is still held. The step time
// comes from three dependent products per mass (velocity times dt, neighbour
// sum times stiffness, acceleration times dt), each formed as two 17 by 31 bit
// partial products per mass on successive cycles, then rounded and then added
// with saturation. Configuration writes are taken in any cycle and must only be
// made while the block is idle.
`default_nettype none

module coupled_oscillator_euler_step #(
    parameter int FRAC_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    coe_in_if.sink       i_in,
    coe_out_if.source    o_out,
    coe_cfg_if.sink      i_cfg
);
    import coe_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    cfg_fire;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign o_out.valid = sts.out_valid;

    coe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.data.action),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    coe_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in.data),
        .i_cfg_fire  (cfg_fire),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

endmodule

`default_nettype wire

[tb/sv/coupled_oscillator_euler_step_test.sv]
// testbench for the three-mass spring chain euler step block
`default_nettype none

module coupled_oscillator_euler_step_test;
    timeunit 1ns;
    timeprecision 1ps;

    import coe_pkg::*;

    localparam int FRAC = 24;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
    localparam longint WORD_MAX_L = longint'(WORD_MAX);
    localparam longint WORD_MIN_L = longint'(WORD_MIN);
    localparam longint HALF_LSB = 64'd1 << (FRAC - 1);
    localparam longint WIDE_CAP = 64'd1 << 40;
    localparam longint STIFF_MASK = 64'h7fff_ffff;
    localparam longint DT_MASK = 64'h01ff_ffff;

    logic clk;
    logic rst_n;

    coe_in_if  in_ch ();
    coe_out_if out_ch ();
    coe_cfg_if cfg_ch ();

    coupled_oscillator_euler_step #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // predicted chain state and registers
    longint chain_pos [3] = '{0, 0, 0};
    longint chain_vel [3] = '{0, 0, 0};
    longint chain_stiff = 64'd1 << FRAC;
    longint chain_dt = (64'd1 << FRAC) / 100;
    bit     clip_hit;

    t_out_item positions_due [$];

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_left = 0;
    int rx_long = 0;
    int quiet_cycles = 0;
    int errors = 0;
    int n_loads = 0;
    int n_steps = 0;
    int n_writes = 0;
    int n_clipped = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // round(a * b / 2^FRAC) with ties away from zero, capped at 2^40
    function automatic longint scale_round(longint a, longint b);
        bit [95:0] mag;
        bit [95:0] prod;
        bit [95:0] q;
        bit        neg;
        neg = (a < 0);
        mag = neg ? 96'(-a) : 96'(a);
        prod = mag * 96'(b);
        q = (prod + 96'(HALF_LSB)) >> FRAC;
        if (q > 96'(WIDE_CAP)) q = 96'(WIDE_CAP);
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint clip_word(longint v);
        if (v > WORD_MAX_L) begin
            clip_hit = 1'b1;
            return WORD_MAX_L;
        end
        if (v < WORD_MIN_L) begin
            clip_hit = 1'b1;
            return WORD_MIN_L;
        end
        return v;
    endfunction

    function automatic t_out_item advance_chain(t_in_item it);
        t_out_item r;
        longint    acc [3];
        clip_hit = 1'b0;
        if (it.action == ACT_LOAD) begin
            chain_pos[0] = longint'($signed(it.init_pos_a));
            chain_vel[0] = longint'($signed(it.init_vel_a));
            chain_pos[1] = longint'($signed(it.init_pos_b));
            chain_vel[1] = longint'($signed(it.init_vel_b));
            chain_pos[2] = longint'($signed(it.init_pos_c));
            chain_vel[2] = longint'($signed(it.init_vel_c));
            n_loads++;
        end else begin
            for (int m = 0; m < 3; m++)
                chain_pos[m] = clip_word(chain_pos[m] + scale_round(chain_vel[m], chain_dt));
            // walls count as zero, neighbour sums stay exact
            acc[0] = clip_word(scale_round(chain_pos[1] - 2 * chain_pos[0], chain_stiff));
            acc[1] = clip_word(scale_round(chain_pos[0] - 2 * chain_pos[1] + chain_pos[2],
                                           chain_stiff));
            acc[2] = clip_word(scale_round(chain_pos[1] - 2 * chain_pos[2], chain_stiff));
            for (int m = 0; m < 3; m++)
                chain_vel[m] = clip_word(chain_vel[m] + scale_round(acc[m], chain_dt));
            n_steps++;
        end
        r.out_pos_a = t_word'(chain_pos[0]);
        r.out_pos_b = t_word'(chain_pos[1]);
        r.out_pos_c = t_word'(chain_pos[2]);
        r.saturated = clip_hit;
        if (clip_hit) n_clipped++;
        return r;
    endfunction

    function automatic t_in_item make_load(t_word pa, t_word va, t_word pb, t_word vb,
                                           t_word pc, t_word vc);
        t_in_item it;
        it.action = ACT_LOAD;
        it.init_pos_a = pa;
        it.init_vel_a = va;
        it.init_pos_b = pb;
        it.init_vel_b = vb;
        it.init_pos_c = pc;
        it.init_vel_c = vc;
        return it;
    endfunction

    // the init fields of a step are junk the block must ignore
    function automatic t_in_item make_step();
        t_in_item it;
        it = make_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        it.action = ACT_STEP;
        return it;
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 5))
            0: return t_word'($urandom);
            1: return WORD_MAX;
            2: return WORD_MIN;
            3: return t_word'($urandom_range(0, 32'h7fff_ffff)) - t_word'(32'h4000_0000);
            default: return t_word'($urandom_range(0, 32'h0fff_ffff)) - t_word'(32'h0800_0000);
        endcase
    endfunction

    task automatic offer_item(t_in_item it);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        repeat (gap) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge clk); while (!in_ch.ready);
        positions_due.push_back(advance_chain(it));
    endtask

    // drop valid after the last beat and wait for every result
    task automatic settle_chain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (positions_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        settle_chain();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == CFG_STIFFNESS)
            chain_stiff = longint'(value) & STIFF_MASK;
        else if (idx == CFG_TIME_STEP)
            chain_dt = longint'(value) & DT_MASK;
        n_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // result side: ready pattern
    always @(negedge clk) begin
        if (rx_long > 0) begin
            rx_left = rx_long;
            rx_long = 0;
        end
        if (rx_left > 0) begin
            out_ch.ready <= 1'b0;
            rx_left--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        t_out_item got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (positions_due.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                want = positions_due.pop_front();
                if (got.out_pos_a !== want.out_pos_a) begin
                    $error("out_pos_a: expected %0d, got %0d", want.out_pos_a, got.out_pos_a);
                    errors++;
                end
                if (got.out_pos_b !== want.out_pos_b) begin
                    $error("out_pos_b: expected %0d, got %0d", want.out_pos_b, got.out_pos_b);
                    errors++;
                end
                if (got.out_pos_c !== want.out_pos_c) begin
                    $error("out_pos_c: expected %0d, got %0d", want.out_pos_c, got.out_pos_c);
                    errors++;
                end
                if (got.saturated !== want.saturated) begin
                    $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
                    errors++;
                end
            end
            rx_left = rx_idle ? $urandom_range(0, 7) : 0;
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: timeout after %0d cycles without a beat", quiet_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // step from zero state, then a swing under the reset registers
    task automatic test_reset_defaults();
        offer_item(make_step());
        offer_item(make_load(32'sd1 <<< FRAC, 0, 0, 0, 0, 32'sd1 <<< (FRAC - 1)));
        repeat (3) offer_item(make_step());
    endtask

    task automatic test_load_extremes();
        offer_item(make_load(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
        offer_item(make_load(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        offer_item(make_load(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                             32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));
        offer_item(make_load(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                             32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa));
        offer_item(make_step());
    endtask

    // dt of one half with no spring: halves round away from zero
    task automatic test_rounding_ties();
        write_reg(CFG_STIFFNESS, 32'd0);
        write_reg(CFG_TIME_STEP, 32'd1 << (FRAC - 1));
        offer_item(make_load(0, 1, 0, -1, 0, 3));
        offer_item(make_step());
        offer_item(make_load(0, -3, 0, 5, 0, -5));
        offer_item(make_step());
    endtask

    task automatic test_saturation();
        // all-ones write leaves the widest stiffness after masking
        write_reg(CFG_STIFFNESS, 32'hffff_ffff);
        write_reg(CFG_TIME_STEP, 32'd1 << FRAC);
        offer_item(make_load(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX));
        offer_item(make_step());
        // alternating extremes give neighbour sums far past 32 bits
        offer_item(make_load(WORD_MIN, 0, WORD_MAX, 0, WORD_MIN, 0));
        offer_item(make_step());
        offer_item(make_step());
        write_reg(CFG_TIME_STEP, 32'd0);
        offer_item(make_load(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, 1, -1));
        offer_item(make_step());
    endtask

    // a write to an unused index must not disturb either register
    task automatic test_spare_index();
        write_reg(CFG_STIFFNESS, 32'd1 << FRAC);
        write_reg(CFG_TIME_STEP, 32'd1 << (FRAC - 4));
        write_reg(CFG_SPARE, $urandom);
        offer_item(make_load(32'sd3 <<< FRAC, 0, -(32'sd1 <<< FRAC), 0, 0, 32'sd1 <<< FRAC));
        offer_item(make_step());
    endtask

    // hold the result side off long enough for the input to back up
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_long = 120;
        offer_item(make_load(pick_word(), pick_word(), pick_word(),
                             pick_word(), pick_word(), pick_word()));
        repeat (15) offer_item(make_step());
        settle_chain();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_runs();
        int sent;
        int run;
        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 5))
                0: write_reg(CFG_STIFFNESS, 32'd0);
                1: write_reg(CFG_STIFFNESS, 32'h7fff_ffff);
                2: write_reg(CFG_STIFFNESS, $urandom);
                default: write_reg(CFG_STIFFNESS, $urandom_range(0, 32'h0400_0000));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(CFG_TIME_STEP, 32'd0);
                1: write_reg(CFG_TIME_STEP, 32'd1 << FRAC);
                2: write_reg(CFG_TIME_STEP, $urandom_range(0, 32'h0100_0000));
                default: write_reg(CFG_TIME_STEP, $urandom_range(0, 32'h0040_0000));
            endcase
            tx_idle = (ph % 4 != 3);
            rx_idle = ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < 68) begin
                if ($urandom_range(0, 9) == 0) begin
                    offer_item(make_load($urandom, $urandom, $urandom,
                                         $urandom, $urandom, $urandom));
                    sent++;
                end else begin
                    offer_item(make_load(pick_word(), pick_word(), pick_word(),
                                         pick_word(), pick_word(), pick_word()));
                    run = $urandom_range(1, 12);
                    repeat (run) offer_item(make_step());
                    sent += run + 1;
                end
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_STIFFNESS;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_load_extremes();
        test_rounding_ties();
        test_saturation();
        test_spare_index();
        test_backpressure();
        test_random_runs();

        settle_chain();
        repeat (20) @(posedge clk);
        $display("tb: %0d loads and %0d steps checked, %0d of them clipped", n_loads, n_steps,
                 n_clipped);
        $display("tb: %0d register writes, long result stall included", n_writes);
        if (errors == 0 && positions_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
